@@ hw/rtl/rdpd_pkg.sv @@
// Shared types and constants of the run-delimited packet deframer.
// No dependencies; the framer, readout and top level refer to it by scoped names.
`timescale 1ns / 1ps

package rdpd_pkg;

  // Packet geometry.
  localparam int PACKET_BYTES  = 65;
  localparam int COUNTER_BYTES = 1;
  localparam int NUM_SAMPLES   = (PACKET_BYTES > COUNTER_BYTES + 1) ?
                                 ((PACKET_BYTES - COUNTER_BYTES) / 2) : 0;
  localparam int MEM_DEPTH     = (NUM_SAMPLES > 2) ? NUM_SAMPLES : 2;
  localparam int SAMPLE_AW     = $clog2(MEM_DEPTH);

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int RUN_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 6;
  localparam int LOST_W   = 16;
  localparam int OUT_W    = 48;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_HEADER_BYTE = 2'd0,
    CFG_HEADER_RUN  = 2'd1,
    CFG_TAIL_BYTE   = 2'd2,
    CFG_TAIL_RUN    = 2'd3
  } cfg_idx_t;

  // Sample readout state.
  typedef enum logic {
    EM_IDLE = 1'b0,
    EM_RUN  = 1'b1
  } emit_state_t;

  // Write request into the sample memory.
  typedef struct packed {
    logic                 we;
    logic [SAMPLE_AW-1:0] addr;
    logic [SAMPLE_W-1:0]  data;
  } mem_wr_t;

  // Accepted packet summary handed from the framer to the readout.
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] seq;
    logic              gap;
    logic [LOST_W-1:0] lost;
  } pkt_info_t;

endpackage

@@ hw/rtl/rdpd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rdpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rdpd_framer.sv @@
// Header/tail hunt, payload write into the sample memory and sequence tracking.
// Depends on rdpd_pkg.
`timescale 1ns / 1ps

module rdpd_framer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [7:0]                cfg_wdata,
  input  logic                      byte_fire,
  input  logic [7:0]                byte_in,
  output rdpd_pkg::mem_wr_t         mem_wr,
  output rdpd_pkg::pkt_info_t       pkt
);

  logic [7:0]  header_byte_r, tail_byte_r;
  logic [3:0]  header_run_r, tail_run_r;
  logic        in_payload_r, in_payload_nxt;
  logic [3:0]  header_seen_r, header_seen_nxt;
  logic [3:0]  tail_seen_r, tail_seen_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  expected_r, expected_nxt;
  logic [15:0] lost_r, lost_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  lo_r, lo_nxt;

  logic [3:0]  hdr_run_eff, tail_run_eff;
  logic [3:0]  hs_inc, ts_inc;
  logic [7:0]  bc_inc;
  logic [8:0]  offset;
  logic        accept;
  logic        gap;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= 8'hFF;
      header_run_r  <= 4'd4;
      tail_byte_r   <= 8'hFE;
      tail_run_r    <= 4'd4;
    end else if (cfg_we) begin
      unique case (rdpd_pkg::cfg_idx_t'(cfg_addr))
        rdpd_pkg::CFG_HEADER_BYTE: header_byte_r <= cfg_wdata;
        rdpd_pkg::CFG_HEADER_RUN:  header_run_r  <= cfg_wdata[3:0];
        rdpd_pkg::CFG_TAIL_BYTE:   tail_byte_r   <= cfg_wdata;
        rdpd_pkg::CFG_TAIL_RUN:    tail_run_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // A run length of zero behaves as one.
  assign hdr_run_eff  = (header_run_r == 4'd0) ? 4'd1 : header_run_r;
  assign tail_run_eff = (tail_run_r == 4'd0) ? 4'd1 : tail_run_r;
  assign hs_inc = (header_seen_r == 4'hF) ? 4'hF : header_seen_r + 4'd1;
  assign ts_inc = (tail_seen_r == 4'hF) ? 4'hF : tail_seen_r + 4'd1;
  assign bc_inc = (byte_count_r == 8'hFF) ? 8'hFF : byte_count_r + 8'd1;
  assign offset = {1'b0, byte_count_r} - 9'(rdpd_pkg::COUNTER_BYTES);
  assign gap    = (seq_r != expected_r);

  // Framing state update for one received word.
  always_comb begin
    in_payload_nxt  = in_payload_r;
    header_seen_nxt = header_seen_r;
    tail_seen_nxt   = tail_seen_r;
    byte_count_nxt  = byte_count_r;
    expected_nxt    = expected_r;
    lost_nxt        = lost_r;
    seq_nxt         = seq_r;
    lo_nxt          = lo_r;
    accept          = 1'b0;
    mem_wr.we       = 1'b0;
    mem_wr.addr     = offset[rdpd_pkg::SAMPLE_AW:1];
    mem_wr.data     = {byte_in, lo_r};
    if (byte_fire) begin
      if (!in_payload_r) begin
        if (byte_in == header_byte_r) begin
          if (hs_inc >= hdr_run_eff) begin
            in_payload_nxt  = 1'b1;
            header_seen_nxt = 4'd0;
            tail_seen_nxt   = 4'd0;
            byte_count_nxt  = 8'd0;
          end else begin
            header_seen_nxt = hs_inc;
          end
        end else begin
          header_seen_nxt = 4'd0;
        end
      end else begin
        // Payload bytes: sequence byte, then little-endian sample pairs.
        if (byte_count_r == 8'd0) begin
          seq_nxt = byte_in;
        end
        if ((byte_count_r >= 8'(rdpd_pkg::COUNTER_BYTES)) &&
            (byte_count_r < 8'(rdpd_pkg::PACKET_BYTES))) begin
          if (!offset[0]) begin
            lo_nxt = byte_in;
          end else if (offset[8:1] < 8'(rdpd_pkg::NUM_SAMPLES)) begin
            mem_wr.we = 1'b1;
          end
        end
        byte_count_nxt = bc_inc;
        if (byte_in == tail_byte_r) begin
          if (ts_inc >= tail_run_eff) begin
            accept = ({1'b0, bc_inc} ==
                      9'(rdpd_pkg::PACKET_BYTES) + {5'd0, tail_run_eff});
            in_payload_nxt  = 1'b0;
            header_seen_nxt = 4'd0;
            tail_seen_nxt   = 4'd0;
            byte_count_nxt  = 8'd0;
          end else begin
            tail_seen_nxt = ts_inc;
          end
        end else begin
          tail_seen_nxt = 4'd0;
        end
      end
    end
    // Sequence tracking of an accepted packet.
    if (accept) begin
      expected_nxt = seq_r + 8'd1;
      if (gap && (lost_r != 16'hFFFF)) begin
        lost_nxt = lost_r + 16'd1;
      end
    end
  end

  assign pkt.start = accept;
  assign pkt.seq   = seq_r;
  assign pkt.gap   = gap;
  assign pkt.lost  = lost_nxt;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r  <= 1'b0;
      header_seen_r <= 4'd0;
      tail_seen_r   <= 4'd0;
      byte_count_r  <= 8'd0;
      expected_r    <= 8'd0;
      lost_r        <= 16'd0;
    end else begin
      in_payload_r  <= in_payload_nxt;
      header_seen_r <= header_seen_nxt;
      tail_seen_r   <= tail_seen_nxt;
      byte_count_r  <= byte_count_nxt;
      expected_r    <= expected_nxt;
      lost_r        <= lost_nxt;
    end
  end

  // Payload holding registers.
  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    lo_r  <= lo_nxt;
  end

endmodule

@@ hw/rtl/rdpd_emit.sv @@
// Sample readout: walks the sample memory and drives the result channel.
// Depends on rdpd_pkg.
`timescale 1ns / 1ps

module rdpd_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rdpd_pkg::pkt_info_t               pkt,
  output logic                              rd_en,
  output logic [rdpd_pkg::SAMPLE_AW-1:0]    rd_addr,
  input  logic [rdpd_pkg::SAMPLE_W-1:0]     rd_data,
  output logic                              busy,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rdpd_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tlast
);

  rdpd_pkg::emit_state_t state_r, state_nxt;

  logic [rdpd_pkg::SAMPLE_AW-1:0] rd_k_r;
  logic [rdpd_pkg::SAMPLE_AW-1:0] pend_k_r;
  logic                           pend_r;
  logic [7:0]                     seq_r;
  logic                           gap_r;
  logic [15:0]                    lost_r;
  logic                           out_valid_r;
  logic [15:0]                    sample_r;
  logic [5:0]                     index_r;
  logic                           last_r;
  logic                           rd_final;

  // A read goes out only when the output register is free at its return.
  assign rd_final = (rd_k_r == rdpd_pkg::SAMPLE_AW'(rdpd_pkg::NUM_SAMPLES - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdpd_pkg::EM_IDLE: begin
        if (pkt.start && (rdpd_pkg::NUM_SAMPLES > 0)) begin
          state_nxt = rdpd_pkg::EM_RUN;
        end
      end
      rdpd_pkg::EM_RUN: begin
        if (rd_en && rd_final) begin
          state_nxt = rdpd_pkg::EM_IDLE;
        end
      end
      default: state_nxt = rdpd_pkg::EM_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    rd_en = 1'b0;
    unique case (state_r)
      rdpd_pkg::EM_IDLE: rd_en = 1'b0;
      rdpd_pkg::EM_RUN:  rd_en = !pend_r && (!out_valid_r || out_tready);
      default:           rd_en = 1'b0;
    endcase
  end

  assign rd_addr = rd_k_r;
  assign busy    = (state_r == rdpd_pkg::EM_RUN) || pend_r || out_valid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdpd_pkg::EM_IDLE;
      rd_k_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pkt.start) begin
        rd_k_r <= '0;
      end else if (rd_en) begin
        rd_k_r <= rd_k_r + 1'b1;
      end
      pend_r <= rd_en;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Packet summary and output payload.
  always_ff @(posedge clk) begin
    if (pkt.start) begin
      seq_r  <= pkt.seq;
      gap_r  <= pkt.gap;
      lost_r <= pkt.lost;
    end
    if (rd_en) begin
      pend_k_r <= rd_k_r;
    end
    if (pend_r) begin
      sample_r <= rd_data;
      index_r  <= 6'(pend_k_r);
      last_r   <= (pend_k_r == rdpd_pkg::SAMPLE_AW'(rdpd_pkg::NUM_SAMPLES - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, lost_r, gap_r, seq_r, index_r, sample_r};
  assign out_tlast  = last_r;

endmodule

@@ hw/rtl/run_delimited_packet_deframer.sv @@
// Run-delimited packet deframer.
// Channels: in_* takes one received byte per word, in_tdata[7:0]. out_* gives
// one signed 16-bit sample per word with its packet information, and tlast
// marks the final sample of a packet. cfg_* writes the header byte, header run,
// tail byte and tail run registers (indexes 0 to 3).
// A packet starts after a run of header bytes and ends at a run of tail bytes;
// only a payload of exactly 65 bytes (sequence byte plus 32 samples) yields
// results, any other length is dropped without output.
// Throughput: a byte is taken every cycle while no packet is being read out.
// After the byte that closes an accepted packet, the 32 samples leave one at a
// time, as the single read port of the sample memory takes a new read only once
// the registered read before it has returned and reached the output register.
// in_tready is low from after the closing byte until the last sample is taken.
// When the receiver stalls, the current sample holds in the output register
// and readout pauses. Reset (rst_n low at a clock edge) returns to the header
// hunt with sequence and loss counters cleared; no memory clearing pass.
// Depends on rdpd_pkg, rdpd_ram, rdpd_framer and rdpd_emit.
`timescale 1ns / 1ps

module run_delimited_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] sample, [21:16] sample_index, [29:22] sequence_res,
  // [30] sequence_gap, [46:31] lost_count, [47] zero
  output logic [47:0] out_tdata,
  output logic        out_tlast    // last
);

  rdpd_pkg::mem_wr_t              mem_wr;
  rdpd_pkg::pkt_info_t            pkt;
  logic                           rd_en;
  logic [rdpd_pkg::SAMPLE_AW-1:0] rd_addr;
  logic [rdpd_pkg::SAMPLE_W-1:0]  rd_data;
  logic                           busy;
  logic                           byte_fire;

  assign in_tready = !busy;
  assign byte_fire = in_tvalid && in_tready;

  rdpd_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .byte_fire (byte_fire),
    .byte_in   (in_tdata),
    .mem_wr    (mem_wr),
    .pkt       (pkt)
  );

  rdpd_ram #(
    .WIDTH (rdpd_pkg::SAMPLE_W),
    .DEPTH (rdpd_pkg::MEM_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rdpd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .pkt        (pkt),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/rdpd_checker.sv @@
// Port-level checks of the deframer, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module rdpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // Reset leaves no sample pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("sample valid after reset");

  // No byte is taken while a sample is on offer.
  a_no_input_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during sample readout");

  // A burst continues after a sample that is not the last one.
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> !in_tready)
    else $error("input reopened before the last sample");

  // A stalled sample holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled sample changed");

endmodule

bind run_delimited_packet_deframer rdpd_checker u_rdpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
